>>> design/fam_pkg.sv
// Package: shared constants and types for the fp32 add/multiply unit.
package fam_pkg;
  localparam int unsigned FracBits = 23;
  localparam int unsigned MantBits = 24;
  localparam int unsigned SumBits  = 25;
  localparam int unsigned ProdBits = 48;

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_MUL = 1'b1
  } op_e;

  typedef logic [31:0] word_t;
endpackage

>>> design/fam_if.sv
// Interfaces: input and output valid/ready channels of the fp32 add/multiply unit.
interface fam_in_if;
  import fam_pkg::*;
  logic  valid;
  logic  ready;
  logic  opcode;
  word_t operand_a;
  word_t operand_b;
  modport source (output valid, opcode, operand_a, operand_b, input ready);
  modport sink   (input valid, opcode, operand_a, operand_b, output ready);
endinterface

interface fam_out_if;
  import fam_pkg::*;
  logic  valid;
  logic  ready;
  word_t result_word;
  modport source (output valid, result_word, input ready);
  modport sink   (input valid, result_word, output ready);
endinterface

>>> design/fp32_add_mul_truncating.sv
// Top level: pipelined truncating fp32 adder and multiplier.
// Usage:
//   in_ch  : opcode (OP_ADD / OP_MUL), operand_a, operand_b; a transfer happens
//            when valid and ready are both high at a rising clk_i edge.
//   out_ch : result_word, one transfer per accepted input, in order.
// Pipeline: four stages (unpack/align or multiply, add/sub or product
//   normalize, normalize and pack, output register).
// Throughput: one operation per cycle while the output is not stalled.
// Stall: the whole pipe advances only when the last stage is empty or its
//   result is taken; empty slots stay in place, nothing is lost or repeated.
// Reset: rst_ni (async, active low) clears all valid bits; payload registers
//   keep whatever they held.
// Add: operands ordered by magnitude, smaller mantissa aligned, added or
//   subtracted in 25 bits, normalized. Multiply: 24x24 product, exponent
//   ea+eb-127, one-place normalization. Everything truncates; exponents wrap.
module fp32_add_mul_truncating
  import fam_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  fam_in_if.sink    in_ch,
  fam_out_if.source out_ch
);

  logic adv;
  logic v1_q, v2_q, v3_q, v4_q;

  // ---------------- stage 1: order/align, or multiply ----------------
  word_t a_s, b_s;
  logic  swap;
  logic [7:0] ea, eb, sh;
  logic [MantBits-1:0] ma, mb, mb_sh;
  logic [ProdBits-1:0] prod;

  always_comb begin
    swap  = (in_ch.operand_b[30:0] > in_ch.operand_a[30:0]);
    a_s   = swap ? in_ch.operand_b : in_ch.operand_a;
    b_s   = swap ? in_ch.operand_a : in_ch.operand_b;
    ea    = a_s[30:23];
    eb    = b_s[30:23];
    sh    = ea - eb;
    ma    = {1'b1, a_s[FracBits-1:0]};
    mb    = {1'b1, b_s[FracBits-1:0]};
    mb_sh = (sh >= 8'(SumBits)) ? '0 : (mb >> sh);
    prod  = {24'd0, 1'b1, in_ch.operand_a[FracBits-1:0]}
          * {24'd0, 1'b1, in_ch.operand_b[FracBits-1:0]};
  end

  logic                op1_q;
  logic                zero1_q;
  logic                sign1_q;
  logic                diff1_q;
  logic [7:0]          e1_q;
  word_t               a1_q;
  logic [MantBits-1:0] ma1_q, mb1_q;
  logic [ProdBits-1:0] p1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op1_q   <= in_ch.opcode;
      a1_q    <= a_s;
      ma1_q   <= ma;
      mb1_q   <= mb_sh;
      diff1_q <= a_s[31] ^ b_s[31];
      p1_q    <= prod;
      if (in_ch.opcode == OP_MUL) begin
        zero1_q <= (in_ch.operand_a == '0) || (in_ch.operand_b == '0);
        sign1_q <= in_ch.operand_a[31] ^ in_ch.operand_b[31];
        e1_q    <= in_ch.operand_a[30:23] + in_ch.operand_b[30:23] + 8'd129;
      end else begin
        zero1_q <= (a_s == '0) || (b_s == '0);
        sign1_q <= a_s[31];
        e1_q    <= ea;
      end
    end
  end

  // ---------------- stage 2: add/sub, or product normalize ----------------
  logic [SumBits-1:0] mbx, sum;
  always_comb begin
    mbx = diff1_q ? (SumBits'(0) - {1'b0, mb1_q}) : {1'b0, mb1_q};
    sum = {1'b0, ma1_q} + mbx;
  end

  logic               op2_q, zero2_q, sign2_q, diff2_q;
  logic [7:0]         e2_q;
  word_t              a2_q;
  logic [SumBits-1:0] m2_q;
  logic [FracBits-1:0] pf2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op2_q   <= op1_q;
      zero2_q <= zero1_q;
      sign2_q <= sign1_q;
      diff2_q <= diff1_q;
      a2_q    <= a1_q;
      m2_q    <= sum;
      if (op1_q == OP_MUL && p1_q[ProdBits-1]) begin
        e2_q  <= e1_q + 8'd1;
        pf2_q <= p1_q[ProdBits-2 -: FracBits];
      end else begin
        e2_q  <= e1_q;
        pf2_q <= p1_q[ProdBits-3 -: FracBits];
      end
    end
  end

  // ---------------- stage 3: sum normalize ----------------
  // Leading-bit count: steps until m[24] != m[23] (24 if none); the exponent caps the shift.
  logic [4:0] lz;
  logic       found;
  logic [7:0] e_n;
  logic [SumBits-1:0] m_n;
  logic [FracBits-1:0] frac3;
  logic [7:0] e3;

  always_comb begin
    lz    = 5'd0;
    found = 1'b0;
    for (int i = 0; i < SumBits - 1; i++) begin
      if (!found && (m2_q[SumBits-1-i] != m2_q[SumBits-2-i])) begin
        lz    = 5'(i);
        found = 1'b1;
      end
    end
    if (!found) lz = 5'(SumBits - 1);
    // loop: e decrements lz times, shifting each time, unless e hits 0 first
    if (m2_q[SumBits-1] && !diff2_q) begin
      e_n = e2_q + 8'd1;
      m_n = m2_q >> 1;
    end else if (m2_q == '0) begin
      // exact cancellation: exponent runs down (or around) to zero
      e_n = 8'd0;
      m_n = '0;
    end else if (e2_q > 8'(lz)) begin
      e_n = e2_q - 8'(lz);
      m_n = m2_q << lz;
    end else if (e2_q == 8'd0) begin
      // wraps to 255 on the first decrement, so every step shifts
      e_n = e2_q - 8'(lz);
      m_n = m2_q << lz;
    end else begin
      e_n = 8'd0;
      m_n = m2_q << (e2_q[4:0] - 5'd1);
    end
    if (op2_q == OP_MUL) begin
      e3    = e2_q;
      frac3 = pf2_q;
    end else begin
      e3    = e_n;
      frac3 = m_n[FracBits-1:0];
    end
  end

  word_t r3_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (zero2_q)
        r3_q <= (op2_q == OP_MUL) ? '0 : a2_q;
      else
        r3_q <= {sign2_q, e3, frac3};
    end
  end

  // ---------------- stage 4: output register ----------------
  word_t r4_q;
  always_ff @(posedge clk_i) begin
    if (adv) r4_q <= r3_q;
  end

  assign adv                = !v4_q || out_ch.ready;
  assign in_ch.ready        = adv;
  assign out_ch.valid       = v4_q;
  assign out_ch.result_word = r4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_ch.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

`ifndef SYNTH
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.ready) |=> (v4_q && $stable(r4_q)))
    else $error("result changed while stalled");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && v3_q) |=> v4_q)
    else $error("item lost between stages");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v4_q |-> in_ch.ready)
    else $error("pipe blocked while empty at output");
`endif

endmodule

>>> tb/fam_checker.sv
// Checker: watches both channels of the fp32 add/multiply unit, predicts and compares results.
module fam_checker
  import fam_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  fam_in_if.sink  in_mon,
  fam_out_if.sink out_mon,
  output int   fail_cnt_o,
  output int   pending_o
);
  word_t result_q[$];
  int    fail_cnt;

  assign fail_cnt_o = fail_cnt;
  assign pending_o  = result_q.size();

  // truncating add: order by magnitude, align, add/sub in 25 bits, normalize
  function automatic word_t fp_sum(word_t a, word_t b);
    word_t       t;
    logic [7:0]  ea, eb, sh, e;
    logic [24:0] ma, mb, m;
    logic        diff;
    if (b[30:0] > a[30:0]) begin
      t = a; a = b; b = t;
    end
    if (a == '0 || b == '0) return a;
    ea = a[30:23];
    eb = b[30:23];
    sh = ea - eb;
    ma = {2'b01, a[22:0]};
    mb = {2'b01, b[22:0]};
    mb = (sh >= SumBits) ? '0 : (mb >> sh);
    diff = a[31] ^ b[31];
    if (diff) mb = -mb;
    m = ma + mb;
    e = ea;
    if (m[24] && !diff) begin
      e = e + 8'd1;
      m = m >> 1;
    end else begin
      for (int n = 0; n < 256; n++) begin
        if (m[24] != m[23]) break;
        e = e - 8'd1;
        if (e == 0) break;
        m = m << 1;
      end
    end
    return {a[31], e, m[22:0]};
  endfunction

  // truncating product: 24x24 mantissas, exponent ea+eb-127 wrapping
  function automatic word_t fp_prod(word_t a, word_t b);
    logic [7:0]  e;
    logic [47:0] p;
    if (a == '0 || b == '0) return '0;
    e = a[30:23] + b[30:23] + 8'd129;
    p = {24'd0, 1'b1, a[22:0]} * {24'd0, 1'b1, b[22:0]};
    if (p[47]) begin
      e = e + 8'd1;
      p = p >> 1;
    end
    return {a[31] ^ b[31], e, p[45:23]};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_q.delete();
      fail_cnt <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        result_q.push_back(op_e'(in_mon.opcode) == OP_MUL ?
                           fp_prod(in_mon.operand_a, in_mon.operand_b) :
                           fp_sum(in_mon.operand_a, in_mon.operand_b));
      if (out_mon.valid && out_mon.ready) begin
        if (result_q.size() == 0) begin
          $error("unexpected result_word transfer: actual %h", out_mon.result_word);
          fail_cnt <= fail_cnt + 1;
        end else begin
          word_t exp_w;
          exp_w = result_q.pop_front();
          if (out_mon.result_word !== exp_w) begin
            $error("result_word mismatch: expected %h actual %h", exp_w,
                   out_mon.result_word);
            fail_cnt <= fail_cnt + 1;
          end
        end
      end
    end
  end
endmodule

>>> tb/fp32_add_mul_truncating_tb.sv
// Testbench top: stimulus, receiver stalls and verdict for the fp32 add/multiply unit.
module fp32_add_mul_truncating_tb;
  import fam_pkg::*;

  localparam int NumRand  = 1350;
  localparam int Watchdog = 5000;  // cycles without any transfer
  localparam int LongHold = 60;    // receiver hold-off, fills the pipe

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_cnt, pending;
  int   idle_cycles = 0;
  bit   calm;       // last part of the run: no idling on either side
  bit   hold_req;   // ask the receiver for one long hold-off
  bit   hold_done;

  fam_in_if  in_ch();
  fam_out_if out_ch();

  fp32_add_mul_truncating uut (.clk_i, .rst_ni, .in_ch(in_ch.sink), .out_ch(out_ch.source));
  fam_checker chk (.clk_i, .rst_ni, .in_mon(in_ch.sink), .out_mon(out_ch.sink),
                   .fail_cnt_o(fail_cnt), .pending_o(pending));

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // random operand: mostly ordinary numbers, with zero, exponent and mantissa corners mixed in
  function automatic word_t rand_word();
    word_t w;
    w = $urandom();
    case ($urandom_range(0, 9))
      0: w = '0;
      1: w[30:23] = $urandom_range(0, 1) ? 8'hff : 8'h00;
      2: w[22:0] = $urandom_range(0, 1) ? '1 : '0;
      default: ;
    endcase
    return w;
  endfunction

  // one transfer on the input channel, with an optional burst of idle cycles first
  task automatic send(op_e op, word_t a, word_t b);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // receiver: random ready bursts, one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
        hold_done = 1'b1;
        out_ch.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog: counts cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > Watchdog) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    word_t dir_a[$], dir_b[$];
    calm = 1'b0;
    hold_req = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_ADD;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: zeros, negative zero, cancellation, big alignment shift, carry out,
    // exponent wrap both ways, all-ones fields
    dir_a = '{32'h0, 32'h3f800000, 32'h0, 32'h80000000, 32'h3f800000, 32'h3f800000,
              32'h4b800000, 32'h3fffffff, 32'h7f7fffff, 32'h00800000, 32'hffffffff,
              32'h3fc00000};
    dir_b = '{32'h0, 32'h0, 32'h40000000, 32'h3f800000, 32'hbf800000, 32'h3f800000,
              32'h33800000, 32'h3fffffff, 32'h7f7fffff, 32'h00800000, 32'hffffffff,
              32'hbfbfffff};
    foreach (dir_a[i]) begin
      send(OP_ADD, dir_a[i], dir_b[i]);
      send(OP_MUL, dir_a[i], dir_b[i]);
    end

    // sender pause until every result is back
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);

    for (int i = 0; i < NumRand; i++) begin
      word_t a, b;
      a = rand_word();
      b = rand_word();
      // near-equal magnitudes exercise deep cancellation in the adder
      if ($urandom_range(0, 4) == 0) b = {~a[31], a[30:23], a[22:0] ^ 23'($urandom_range(0, 15))};
      if (i == 300) hold_req = 1'b1;  // receiver stalls while sender keeps offering
      if (i == NumRand - 150) calm = 1'b1;
      send(op_e'($urandom_range(0, 1)), a, b);
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (fail_cnt == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
